/* hw/rtl/gesh_pkg.sv */
// ----------------------------------------------------------------------------
// Grain envelope shaper package
// Shared widths, fixed-point constants, register indexes and payload types.
// ----------------------------------------------------------------------------
package gesh_pkg;

  // Field widths fixed by the block's interface.
  localparam int unsigned SAMPLE_BITS    = 16;
  localparam int unsigned GAIN_FRAC_BITS = 24;
  localparam int unsigned LENGTH_BITS    = 20;

  // Envelope gain is Q2.F, steps are Q1.F, position has two spare bits.
  localparam int unsigned GAIN_W = GAIN_FRAC_BITS + 2;
  localparam int unsigned STEP_W = GAIN_FRAC_BITS + 1;
  localparam int unsigned POS_W  = LENGTH_BITS + 2;

  // Q1.15 scaling for overall gain and pan weights.
  localparam int unsigned Q15_W    = 16;
  localparam int unsigned Q15_FRAC = 15;
  localparam logic [Q15_W-1:0] Q15_ONE  = Q15_W'(2 ** Q15_FRAC);
  localparam logic [Q15_W-1:0] PAN_HALF = Q15_W'(2 ** (Q15_FRAC - 1));

  // Sample magnitude after envelope scaling can reach about twice full scale.
  localparam int unsigned MAG_W = SAMPLE_BITS + 1;
  localparam logic [MAG_W-1:0] MAG_POS_LIM = MAG_W'(2 ** (SAMPLE_BITS - 1) - 1);
  localparam logic [MAG_W-1:0] MAG_NEG_LIM = MAG_W'(2 ** (SAMPLE_BITS - 1));

  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(2 ** GAIN_FRAC_BITS);
  localparam logic [STEP_W-1:0] STEP_ONE = STEP_W'(2 ** GAIN_FRAC_BITS);
  // Minimum gain is -100 dB, rounded to the nearest code.
  localparam logic [GAIN_W-1:0] MIN_GAIN =
    GAIN_W'((2 ** GAIN_FRAC_BITS + 50000) / 100000);

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W =
    (STEP_W > LENGTH_BITS) ? ((STEP_W > Q15_W) ? STEP_W : Q15_W)
                           : ((LENGTH_BITS > Q15_W) ? LENGTH_BITS : Q15_W);

  localparam logic [CFG_IDX_W-1:0] REG_ATTACK_LEN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_LEN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_LEN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK_STEP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_STEP = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OVERALL_GAIN = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PAN_LEFT     = 3'd6;

  // Default number of multiplier bits consumed per cycle.
  localparam int unsigned DIGIT_BITS_DEF = 2;

  typedef struct packed {
    logic                          op;
    logic signed [SAMPLE_BITS-1:0] sample_in;
  } gesh_in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
    logic                          grain_active;
  } gesh_out_t;

  typedef struct packed {
    logic [LENGTH_BITS-1:0] attack_len;
    logic [LENGTH_BITS-1:0] hold_len;
    logic [LENGTH_BITS-1:0] release_len;
    logic [STEP_W-1:0]      attack_step;
    logic [STEP_W-1:0]      release_step;
    logic [Q15_W-1:0]       overall_gain;
    logic [Q15_W-1:0]       pan_left;
  } gesh_cfg_t;

  localparam gesh_cfg_t CFG_RESET = '{
    attack_len:   '0,
    hold_len:     '0,
    release_len:  '0,
    attack_step:  STEP_ONE,
    release_step: STEP_ONE,
    overall_gain: Q15_ONE,
    pan_left:     PAN_HALF
  };

  typedef enum logic [3:0] {
    PH_OFF     = 4'b0001,
    PH_ATTACK  = 4'b0010,
    PH_HOLD    = 4'b0100,
    PH_RELEASE = 4'b1000
  } gesh_phase_e;

  typedef struct packed {
    gesh_phase_e       phase;
    logic [GAIN_W-1:0] gain;
    logic [STEP_W-1:0] step;
  } gesh_env_t;

  // Strobes from the sequencer to the envelope tracker.
  typedef struct packed {
    logic start;
    logic advance;
    logic gain_wr;
  } gesh_env_ctrl_t;

endpackage

/* hw/rtl/gesh_serial_mul.sv */
// ----------------------------------------------------------------------------
// Digit-serial unsigned multiplier
// Shift-and-add over the multiplier, DIGIT_BITS bits per cycle, LSB first.
// ----------------------------------------------------------------------------
module gesh_serial_mul #(
  parameter int unsigned MCAND_W    = 16,
  parameter int unsigned MPLIER_W   = 16,
  parameter int unsigned DIGIT_BITS = 2
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         load_i,
  input  logic [MCAND_W-1:0]           mcand_i,
  input  logic [MPLIER_W-1:0]          mplier_i,
  output logic                         done_o,
  output logic [MCAND_W+MPLIER_W-1:0]  product_o
);

  localparam int unsigned NUM_DIGITS = (MPLIER_W + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int unsigned PAD_W      = NUM_DIGITS * DIGIT_BITS;
  localparam int unsigned ACC_W      = MCAND_W + DIGIT_BITS;
  localparam int unsigned PROD_W     = MCAND_W + PAD_W;
  localparam int unsigned CNT_W      = $clog2(NUM_DIGITS + 1);

  logic [MCAND_W-1:0] mcand_q;
  logic [PROD_W-1:0]  prod_q, prod_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [ACC_W-1:0]   partial;
  logic [ACC_W-1:0]   acc;

  // The upper part of the product register accumulates, the lower part
  // holds the multiplier digits not yet consumed.
  always_comb begin
    partial = ACC_W'(mcand_q) * ACC_W'(prod_q[DIGIT_BITS-1:0]);
    acc     = ACC_W'(prod_q[PROD_W-1:PAD_W]) + partial;
    prod_d  = prod_q;
    if (load_i) begin
      prod_d = PROD_W'(mplier_i);
    end else if (busy_q) begin
      prod_d = {acc, prod_q[PAD_W-1:DIGIT_BITS]};
    end
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = busy_q && (cnt_q == CNT_W'(1));
    if (load_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(NUM_DIGITS);
    end else if (busy_q) begin
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      mcand_q <= mcand_i;
    end
    prod_q <= prod_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  assign done_o    = done_q;
  assign product_o = prod_q[MCAND_W+MPLIER_W-1:0];

endmodule

/* hw/rtl/gesh_envelope.sv */
// ----------------------------------------------------------------------------
// Grain envelope tracker
// Holds grain position, alive flag, envelope phase, gain and step.
// ----------------------------------------------------------------------------
module gesh_envelope import gesh_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gesh_cfg_t         cfg_i,
  input  gesh_env_ctrl_t    ctrl_i,
  input  logic [GAIN_W-1:0] gain_new_i,
  output logic [GAIN_W-1:0] gain_o,
  output logic [STEP_W-1:0] step_o,
  output logic              alive_o
);

  gesh_env_t             env_q, env_d, env_mid;
  logic [POS_W-1:0]      pos_q, pos_d, pos_inc;
  logic                  alive_q, alive_d;
  logic [LENGTH_BITS:0]  ah_sum;
  logic [POS_W-1:0]      total_sum;

  // Entering a phase with zero length falls through to the following one.
  function automatic gesh_env_t enter_phase(gesh_phase_e req, gesh_env_t cur,
                                            gesh_cfg_t cfg);
    gesh_phase_e ph;
    gesh_env_t   nxt;
    ph  = req;
    nxt = cur;
    if (ph == PH_ATTACK && cfg.attack_len == '0) begin
      ph = PH_HOLD;
    end
    if (ph == PH_HOLD && cfg.hold_len == '0) begin
      nxt.gain = GAIN_ONE;
      ph       = PH_RELEASE;
    end
    if (ph == PH_RELEASE && cfg.release_len == '0) begin
      ph = PH_OFF;
    end
    nxt.phase = ph;
    case (ph)
      PH_OFF: begin
        nxt.gain = '0;
      end
      PH_ATTACK: begin
        nxt.step = cfg.attack_step;
        nxt.gain = MIN_GAIN;
      end
      PH_HOLD: begin
        nxt.gain = GAIN_ONE;
        nxt.step = STEP_ONE;
      end
      PH_RELEASE: begin
        nxt.step = (cfg.release_step > STEP_ONE) ? STEP_ONE : cfg.release_step;
      end
      default: begin
        nxt.gain = '0;
      end
    endcase
    return nxt;
  endfunction

  always_comb begin
    ah_sum    = {1'b0, cfg_i.attack_len} + {1'b0, cfg_i.hold_len};
    total_sum = {1'b0, ah_sum} + POS_W'(cfg_i.release_len);
    pos_inc   = pos_q + POS_W'(1);
    env_mid   = env_q;
    env_d     = env_q;
    pos_d     = pos_q;
    alive_d   = alive_q;
    if (ctrl_i.start) begin
      pos_d   = '0;
      alive_d = 1'b1;
      env_d   = enter_phase(PH_ATTACK, env_q, cfg_i);
    end else if (ctrl_i.advance) begin
      if (pos_inc == POS_W'(ah_sum)) begin
        env_mid = enter_phase(PH_RELEASE, env_mid, cfg_i);
      end
      if (pos_inc == total_sum) begin
        pos_d   = '0;
        alive_d = 1'b0;
      end else begin
        pos_d = pos_inc;
      end
      if (env_mid.phase == PH_ATTACK && env_mid.gain >= GAIN_ONE) begin
        env_mid = enter_phase(PH_HOLD, env_mid, cfg_i);
      end
      if (env_mid.phase == PH_RELEASE && env_mid.gain < MIN_GAIN) begin
        env_mid = enter_phase(PH_OFF, env_mid, cfg_i);
      end
      env_d = env_mid;
    end else if (ctrl_i.gain_wr) begin
      env_d.gain = gain_new_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      env_q   <= '{phase: PH_OFF, gain: '0, step: STEP_ONE};
      pos_q   <= '0;
      alive_q <= 1'b0;
    end else begin
      env_q   <= env_d;
      pos_q   <= pos_d;
      alive_q <= alive_d;
    end
  end

  assign gain_o  = env_q.gain;
  assign step_o  = env_q.step;
  assign alive_o = alive_q;

endmodule

/* hw/rtl/grain_envelope_shaper.sv */
// ----------------------------------------------------------------------------
// Grain envelope shaper
// Exponential attack-hold-release envelope with gain and stereo pan.
// ----------------------------------------------------------------------------
// Each input beat is either a start command, which re-arms the grain at
// position zero in the attack phase at -100 dB, skipping phases of zero
// length, or a source sample, which advances the grain, updates the envelope
// gain by the per-phase step and yields one output beat: the sample scaled by
// envelope, overall gain and the left and right pan weights, each rounded
// half away from zero and saturated to the sample width. Every input beat
// gives exactly one output beat. A start command, or a sample that arrives
// while the grain is dead, goes from IDLE through PREP straight to OUT and
// yields a silent beat. A live sample runs through four digit-serial
// multiplications in turn (gain times step, sample times gain, overall gain,
// then left and right pan in parallel) in the states GAIN, ENV, OG and PAN.
// One beat is worked on at a time; a finished output beat waits in the output
// register, and the next input beat is taken while it waits. Configuration
// registers are written through a plain write port and must only change
// while the block is idle.
// ----------------------------------------------------------------------------
module grain_envelope_shaper import gesh_pkg::*; #(
  parameter int unsigned DIGIT_BITS = DIGIT_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Sample and start beats.
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  gesh_in_t              in_data_i,
  // Shaped stereo beats.
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output gesh_out_t             out_data_o,
  // Configuration write port.
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  // Product widths of the four multiplications.
  localparam int unsigned PA_W = GAIN_W + STEP_W;
  localparam int unsigned PB_W = GAIN_W + SAMPLE_BITS;
  localparam int unsigned PC_W = MAG_W + Q15_W;
  localparam int unsigned RA_W = PA_W + 1 - GAIN_FRAC_BITS;

  // Sequencer states, one-hot.
  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_PREP = 7'b0000010,
    ST_GAIN = 7'b0000100,
    ST_ENV  = 7'b0001000,
    ST_OG   = 7'b0010000,
    ST_PAN  = 7'b0100000,
    ST_OUT  = 7'b1000000
  } state_e;

  state_e                 state_q, state_d;
  logic                   launch_q, launch_d;
  logic                   op_q;
  logic                   neg_q;
  logic [SAMPLE_BITS-1:0] mag_q, mag_d;
  logic                   zero_q, zero_d;
  logic                   out_valid_q, out_valid_d;
  gesh_out_t              out_data_q, out_data_d;
  logic                   out_load;
  logic                   in_accept;

  gesh_cfg_t              cfg_q;
  gesh_env_ctrl_t         env_ctrl;
  logic [GAIN_W-1:0]      env_gain;
  logic [STEP_W-1:0]      env_step;
  logic                   alive;

  logic                   done_a, done_b, done_c, done_l, done_r;
  logic [PA_W-1:0]        prod_a;
  logic [PB_W-1:0]        prod_b;
  logic [PC_W-1:0]        prod_c, prod_l, prod_r;

  logic [PA_W:0]          sum_a;
  logic [RA_W-1:0]        rnd_a;
  logic [GAIN_W-1:0]      gain_new;
  logic [PB_W:0]          sum_b;
  logic [PC_W:0]          sum_c, sum_l, sum_r;
  logic [MAG_W-1:0]       mag_env, mag_og, mag_l, mag_r;
  logic [Q15_W-1:0]       og_clamp, pl_clamp, pr_weight;

  // Saturate a sign and magnitude pair to a two's complement sample.
  function automatic logic [SAMPLE_BITS-1:0] sat_out(logic neg,
                                                     logic [MAG_W-1:0] mag);
    logic [SAMPLE_BITS-1:0] res;
    if (!neg) begin
      res = (mag > MAG_POS_LIM) ? MAG_POS_LIM[SAMPLE_BITS-1:0]
                                : mag[SAMPLE_BITS-1:0];
    end else begin
      res = (mag > MAG_NEG_LIM) ? MAG_NEG_LIM[SAMPLE_BITS-1:0]
                                : SAMPLE_BITS'(0) - mag[SAMPLE_BITS-1:0];
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers. Indexes beyond the list are ignored.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_ATTACK_LEN:   cfg_q.attack_len   <= cfg_wdata_i[LENGTH_BITS-1:0];
        REG_HOLD_LEN:     cfg_q.hold_len     <= cfg_wdata_i[LENGTH_BITS-1:0];
        REG_RELEASE_LEN:  cfg_q.release_len  <= cfg_wdata_i[LENGTH_BITS-1:0];
        REG_ATTACK_STEP:  cfg_q.attack_step  <= cfg_wdata_i[STEP_W-1:0];
        REG_RELEASE_STEP: cfg_q.release_step <= cfg_wdata_i[STEP_W-1:0];
        REG_OVERALL_GAIN: cfg_q.overall_gain <= cfg_wdata_i[Q15_W-1:0];
        REG_PAN_LEFT:     cfg_q.pan_left     <= cfg_wdata_i[Q15_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Weights above unity behave as unity; the right weight is the complement.
  assign og_clamp  = (cfg_q.overall_gain > Q15_ONE) ? Q15_ONE : cfg_q.overall_gain;
  assign pl_clamp  = (cfg_q.pan_left > Q15_ONE) ? Q15_ONE : cfg_q.pan_left;
  assign pr_weight = Q15_ONE - pl_clamp;

  // --------------------------------------------------------------------------
  // Envelope state: position, phase, gain and step of the current grain.
  // --------------------------------------------------------------------------
  gesh_envelope u_envelope (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .ctrl_i     (env_ctrl),
    .gain_new_i (gain_new),
    .gain_o     (env_gain),
    .step_o     (env_step),
    .alive_o    (alive)
  );

  // --------------------------------------------------------------------------
  // Multiplier chain. The sample is carried as sign and magnitude, so every
  // product is unsigned and rounding half up on the magnitude matches rounding
  // half away from zero on the signed value.
  // --------------------------------------------------------------------------

  // New envelope gain: gain times step, rounded, saturated to the gain width.
  gesh_serial_mul #(
    .MCAND_W    (GAIN_W),
    .MPLIER_W   (STEP_W),
    .DIGIT_BITS (DIGIT_BITS)
  ) u_mul_gain (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (launch_q && state_q == ST_GAIN),
    .mcand_i   (env_gain),
    .mplier_i  (env_step),
    .done_o    (done_a),
    .product_o (prod_a)
  );

  assign sum_a    = {1'b0, prod_a} + ((PA_W + 1)'(1) << (GAIN_FRAC_BITS - 1));
  assign rnd_a    = sum_a[PA_W:GAIN_FRAC_BITS];
  assign gain_new = (|rnd_a[RA_W-1:GAIN_W]) ? '1 : rnd_a[GAIN_W-1:0];

  // Sample magnitude times the updated envelope gain.
  gesh_serial_mul #(
    .MCAND_W    (GAIN_W),
    .MPLIER_W   (SAMPLE_BITS),
    .DIGIT_BITS (DIGIT_BITS)
  ) u_mul_env (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (launch_q && state_q == ST_ENV),
    .mcand_i   (env_gain),
    .mplier_i  (mag_q),
    .done_o    (done_b),
    .product_o (prod_b)
  );

  assign sum_b   = {1'b0, prod_b} + ((PB_W + 1)'(1) << (GAIN_FRAC_BITS - 1));
  assign mag_env = sum_b[GAIN_FRAC_BITS +: MAG_W];

  // Overall grain gain.
  gesh_serial_mul #(
    .MCAND_W    (MAG_W),
    .MPLIER_W   (Q15_W),
    .DIGIT_BITS (DIGIT_BITS)
  ) u_mul_og (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (launch_q && state_q == ST_OG),
    .mcand_i   (mag_env),
    .mplier_i  (og_clamp),
    .done_o    (done_c),
    .product_o (prod_c)
  );

  assign sum_c  = {1'b0, prod_c} + ((PC_W + 1)'(1) << (Q15_FRAC - 1));
  assign mag_og = sum_c[Q15_FRAC +: MAG_W];

  // Left and right pan weights run side by side.
  gesh_serial_mul #(
    .MCAND_W    (MAG_W),
    .MPLIER_W   (Q15_W),
    .DIGIT_BITS (DIGIT_BITS)
  ) u_mul_left (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (launch_q && state_q == ST_PAN),
    .mcand_i   (mag_og),
    .mplier_i  (pl_clamp),
    .done_o    (done_l),
    .product_o (prod_l)
  );

  gesh_serial_mul #(
    .MCAND_W    (MAG_W),
    .MPLIER_W   (Q15_W),
    .DIGIT_BITS (DIGIT_BITS)
  ) u_mul_right (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (launch_q && state_q == ST_PAN),
    .mcand_i   (mag_og),
    .mplier_i  (pr_weight),
    .done_o    (done_r),
    .product_o (prod_r)
  );

  assign sum_l = {1'b0, prod_l} + ((PC_W + 1)'(1) << (Q15_FRAC - 1));
  assign sum_r = {1'b0, prod_r} + ((PC_W + 1)'(1) << (Q15_FRAC - 1));
  assign mag_l = sum_l[Q15_FRAC +: MAG_W];
  assign mag_r = sum_r[Q15_FRAC +: MAG_W];

  // --------------------------------------------------------------------------
  // Sequencer. The input is taken only in IDLE; the finished beat goes to the
  // output register as soon as that register is free or being emptied.
  // --------------------------------------------------------------------------
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;

  always_comb begin
    state_d  = state_q;
    launch_d = 1'b0;
    zero_d   = zero_q;
    env_ctrl = '0;
    out_load = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        if (op_q) begin
          // Start beat: re-arm the grain, silent output.
          env_ctrl.start = 1'b1;
          zero_d         = 1'b1;
          state_d        = ST_OUT;
        end else if (!alive) begin
          // Dead grain: silent output, state untouched.
          zero_d  = 1'b1;
          state_d = ST_OUT;
        end else begin
          env_ctrl.advance = 1'b1;
          zero_d           = 1'b0;
          launch_d         = 1'b1;
          state_d          = ST_GAIN;
        end
      end
      ST_GAIN: begin
        if (done_a) begin
          env_ctrl.gain_wr = 1'b1;
          launch_d         = 1'b1;
          state_d          = ST_ENV;
        end
      end
      ST_ENV: begin
        if (done_b) begin
          launch_d = 1'b1;
          state_d  = ST_OG;
        end
      end
      ST_OG: begin
        if (done_c) begin
          launch_d = 1'b1;
          state_d  = ST_PAN;
        end
      end
      ST_PAN: begin
        if (done_l) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Split the incoming sample into sign and magnitude.
  assign mag_d = in_data_i.sample_in[SAMPLE_BITS-1]
               ? SAMPLE_BITS'(0) - in_data_i.sample_in
               : in_data_i.sample_in;

  always_comb begin
    out_data_d.left_out     = zero_q ? '0 : sat_out(neg_q, mag_l);
    out_data_d.right_out    = zero_q ? '0 : sat_out(neg_q, mag_r);
    out_data_d.grain_active = alive;
    out_valid_d             = out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q  <= in_data_i.op;
      neg_q <= in_data_i.sample_in[SAMPLE_BITS-1];
      mag_q <= mag_d;
    end
    if (out_load) begin
      out_data_q <= out_data_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      launch_q    <= 1'b0;
      zero_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      launch_q    <= launch_d;
      zero_q      <= zero_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------

  // Both pan multipliers are launched together and must finish together.
  a_pan_lockstep : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_l == done_r)
    else $error("pan multipliers out of step");

  // An output beat only appears from the hand-off state of the sequencer.
  a_out_from_seq : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_OUT))
    else $error("output beat raised outside the hand-off state");

  // A start beat always leaves the grain alive.
  a_start_arms : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PREP && op_q) |=> alive)
    else $error("start beat did not arm the grain");

  // A silent sample beat only comes from a dead grain.
  a_silent_dead : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && zero_q && !op_q) |-> !alive)
    else $error("silent sample beat from a live grain");

endmodule
